// ===== sv/ftrp_pkg.sv =====
// ----------------------------------------------------------------------------
// ftrp_pkg
// Types, constants and codes shared by the fan tachometer block.
// ----------------------------------------------------------------------------
package ftrp_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int TIME_BITS_DEF = 32;

  localparam int RPM_W      = 16;
  localparam int OUT_CH     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = RPM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_WIRE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = 3'd6;

  // register reset values
  localparam logic [15:0] SAMPLE_RST    = 16'd100;
  localparam logic [14:0] THRESHOLD_RST = 15'd100;
  localparam logic [15:0] DEBOUNCE_RST  = 16'd1500;
  localparam logic [15:0] STALE_RST     = 16'd1000;
  localparam logic [15:0] NUMERATOR_RST = 16'd30000;

  typedef struct packed {
    logic       command;
    logic [1:0] channel;
    logic [3:0] fan_on_mask;
  } in_item_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm_fan0;
    logic [RPM_W-1:0] rpm_fan1;
    logic [RPM_W-1:0] rpm_fan2;
    logic [RPM_W-1:0] rpm_fan3;
    logic [3:0]       present_mask;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SAMPLE,
    ST_DIV,
    ST_COMMIT,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic tick_inc;
    logic sample_take;
    logic div_start;
    logic div_step;
    logic div_commit;
    logic sweep_init;
    logic eval_presence;
    logic sweep_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic edge_go;
    logic sample_due;
    logic div_last;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/ftrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftrp_ctrl
// Sequencer: decode an item, run the divider or sampling, sweep channels, emit.
// ----------------------------------------------------------------------------
module ftrp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ftrp_pkg::dp_status_t   status,
  output ftrp_pkg::ctrl_cmd_t    cmd
);
  import ftrp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_tick) begin
          cmd.tick_inc = 1'b1;
          state_nxt    = ST_SAMPLE;
        end else if (status.edge_go) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.sweep_init = 1'b1;
          state_nxt      = ST_SWEEP;
        end
      end
      ST_SAMPLE: begin
        cmd.sweep_init    = 1'b1;
        cmd.eval_presence = status.sample_due;
        cmd.sample_take   = status.sample_due;
        state_nxt         = ST_SWEEP;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.div_commit = 1'b1;
        cmd.sweep_init = 1'b1;
        state_nxt      = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ftrp_dp.sv =====
// ----------------------------------------------------------------------------
// ftrp_dp
// Datapath: configuration, time base, per-channel state, divider, result.
// ----------------------------------------------------------------------------
module ftrp_dp #(
  parameter int CHANNELS  = ftrp_pkg::CHANNELS_DEF,
  parameter int TIME_BITS = ftrp_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ftrp_pkg::in_item_t                   in_data,
  input  logic                                 cfg_valid,
  input  logic [ftrp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ftrp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output ftrp_pkg::out_item_t                  out_data,
  input  ftrp_pkg::ctrl_cmd_t                  cmd,
  output ftrp_pkg::dp_status_t                 status
);
  import ftrp_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [3:0]  enable_r;
  logic [3:0]  two_wire_r;
  logic [15:0] sample_r;
  logic [14:0] threshold_r;
  logic [15:0] debounce_r;
  logic [15:0] stale_r;
  logic [15:0] numerator_r;

  // time base and per-channel state
  logic [TIME_BITS-1:0] time_now_r;
  logic [TIME_BITS-1:0] last_sample_r;
  logic [TIME_BITS-1:0] last_edge_r  [CHANNELS];
  logic [RPM_W-1:0]     edge_rpm_r   [CHANNELS];
  logic [CHANNELS-1:0]  edge_valid_r;
  logic [TIME_BITS-1:0] miss_start_r [CHANNELS];
  logic [CHANNELS-1:0]  miss_active_r;
  logic [CHANNELS-1:0]  present_r;

  // item and sweep
  in_item_t             item_r;
  logic [CH_W-1:0]      idx_r;
  logic                 eval_r;
  logic [RPM_W-1:0]     rpm_work_r [OUT_CH];

  // divider
  logic [TIME_BITS-1:0] period_r;
  logic [TIME_BITS-1:0] rem_r;
  logic [RPM_W-1:0]     num_sh_r;
  logic [RPM_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  // output register
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [7:0]           en8;
  logic [7:0]           tw8;
  logic [7:0]           on8;
  logic [7:0]           wr8;
  logic [2:0]           idx3;
  logic [TIME_BITS-1:0] el_edge;
  logic [TIME_BITS-1:0] el_miss;
  logic [TIME_BITS-1:0] el_sample;
  logic [RPM_W-1:0]     cur_rpm;
  logic [TIME_BITS:0]   trial;
  logic                 trial_ge;
  logic [3:0]           present4;
  logic [RPM_W-1:0]     rpm_fld [OUT_CH];

  assign en8       = {4'b0, enable_r};
  assign tw8       = {4'b0, two_wire_r};
  assign on8       = {4'b0, item_r.fan_on_mask};
  assign wr8       = {4'b0, cfg_wdata[3:0]};
  assign idx3      = 3'(idx_r);
  assign el_edge   = time_now_r - last_edge_r[idx_r];
  assign el_miss   = time_now_r - miss_start_r[idx_r];
  assign el_sample = time_now_r - last_sample_r;
  assign cur_rpm   = (en8[idx3] && edge_valid_r[idx_r] && (el_edge <= TIME_BITS'(stale_r)))
                     ? edge_rpm_r[idx_r] : '0;

  assign trial    = {rem_r, num_sh_r[RPM_W-1]};
  assign trial_ge = (trial >= {1'b0, period_r});

  assign status.is_tick    = (item_r.command == CMD_TICK);
  assign status.edge_go    = (int'(item_r.channel) < CHANNELS) && en8[{1'b0, item_r.channel}];
  assign status.sample_due = (el_sample >= TIME_BITS'(sample_r));
  assign status.div_last   = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign status.sweep_last = (idx_r == CH_W'(CHANNELS - 1));
  assign status.out_free   = !out_valid_r || out_ready;

  // channels beyond CHANNELS read as zero rpm and absent
  for (genvar g = 0; g < OUT_CH; g++) begin : g_out
    if (g < CHANNELS) begin : g_live
      assign rpm_fld[g]  = rpm_work_r[g];
      assign present4[g] = present_r[g];
    end else begin : g_none
      assign rpm_fld[g]  = '0;
      assign present4[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= '0;
      two_wire_r    <= '0;
      sample_r      <= SAMPLE_RST;
      threshold_r   <= THRESHOLD_RST;
      debounce_r    <= DEBOUNCE_RST;
      stale_r       <= STALE_RST;
      numerator_r   <= NUMERATOR_RST;
      time_now_r    <= '0;
      last_sample_r <= '0;
      edge_valid_r  <= '0;
      miss_active_r <= '0;
      present_r     <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_edge_r[i]  <= '0;
        edge_rpm_r[i]   <= '0;
        miss_start_r[i] <= '0;
      end
    end else begin
      // configuration writes: the user issues them only while the sequencer is idle; the block does not enforce it
      if (cfg_valid) begin
        case (cfg_index)
          REG_ENABLE: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (wr8[3'(i)] && !en8[3'(i)]) begin
                last_edge_r[i]  <= '0;
                edge_rpm_r[i]   <= '0;
                edge_valid_r[i] <= 1'b0;
              end else if (!wr8[3'(i)]) begin
                edge_valid_r[i] <= 1'b0;
              end
            end
            enable_r <= cfg_wdata[3:0];
          end
          REG_TWO_WIRE:  two_wire_r  <= cfg_wdata[3:0];
          REG_SAMPLE:    sample_r    <= cfg_wdata;
          REG_THRESHOLD: threshold_r <= cfg_wdata[14:0];
          REG_DEBOUNCE:  debounce_r  <= cfg_wdata;
          REG_STALE:     stale_r     <= cfg_wdata;
          REG_NUMERATOR: numerator_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.tick_inc) begin
        time_now_r <= time_now_r + 1'b1;
      end
      if (cmd.sample_take) begin
        last_sample_r <= time_now_r;
      end

      if (cmd.div_commit) begin
        edge_rpm_r[idx_r]   <= (period_r == '0) ? '0 : quo_r;
        last_edge_r[idx_r]  <= time_now_r;
        edge_valid_r[idx_r] <= 1'b1;
      end

      // presence of the swept channel
      if (cmd.sweep_step && eval_r) begin
        if (tw8[idx3]) begin
          present_r[idx_r]     <= 1'b1;
          miss_active_r[idx_r] <= 1'b0;
          miss_start_r[idx_r]  <= '0;
        end else if (!on8[idx3]) begin
          miss_active_r[idx_r] <= 1'b0;
          miss_start_r[idx_r]  <= '0;
        end else if (cur_rpm >= {1'b0, threshold_r}) begin
          present_r[idx_r]     <= 1'b1;
          miss_active_r[idx_r] <= 1'b0;
          miss_start_r[idx_r]  <= '0;
        end else if (!miss_active_r[idx_r]) begin
          miss_active_r[idx_r] <= 1'b1;
          miss_start_r[idx_r]  <= time_now_r;
        end else if (el_miss >= TIME_BITS'(debounce_r)) begin
          present_r[idx_r] <= 1'b0;
        end
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
      idx_r  <= CH_W'(in_data.channel);
    end else if (cmd.sweep_init) begin
      idx_r  <= '0;
      eval_r <= cmd.eval_presence;
    end else if (cmd.sweep_step && !status.sweep_last) begin
      idx_r <= idx_r + 1'b1;
    end

    if (cmd.sweep_step && (int'(idx_r) < OUT_CH)) begin
      rpm_work_r[2'(idx_r)] <= cur_rpm;
    end

    // restoring divide: one quotient bit per cycle
    if (cmd.div_start) begin
      period_r <= el_edge;
      rem_r    <= '0;
      num_sh_r <= numerator_r;
      quo_r    <= '0;
      cnt_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= trial_ge ? TIME_BITS'(trial - {1'b0, period_r}) : trial[TIME_BITS-1:0];
      quo_r    <= {quo_r[RPM_W-2:0], trial_ge};
      num_sh_r <= {num_sh_r[RPM_W-2:0], 1'b0};
      cnt_r    <= cnt_r + 1'b1;
    end

    if (cmd.out_load) begin
      out_data_r.rpm_fan0     <= rpm_fld[0];
      out_data_r.rpm_fan1     <= rpm_fld[1];
      out_data_r.rpm_fan2     <= rpm_fld[2];
      out_data_r.rpm_fan3     <= rpm_fld[3];
      out_data_r.present_mask <= present4;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/fan_tach_rpm_presence.sv =====
// Path from input transfer to out_valid: decode; then sampling for a tick, the
// divider and commit for a tach edge on an enabled channel; then sweep, emit.
// Throughput: one item at a time; the next transfer is taken the cycle after
// the result is loaded. The 16-step divider and the channel sweep set this.
// Reset (rst_n low, synchronous): time base, edge state, miss timers and
// presence clear; registers take their defaults; no result pending.
// ----------------------------------------------------------------------------
// fan_tach_rpm_presence
// Four-channel fan tachometer with rpm measurement and presence detection.
// ----------------------------------------------------------------------------
module fan_tach_rpm_presence #(
  parameter int CHANNELS  = ftrp_pkg::CHANNELS_DEF,
  parameter int TIME_BITS = ftrp_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // item channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ftrp_pkg::in_item_t                in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output ftrp_pkg::out_item_t               out_data,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ftrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftrp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ftrp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register writes are always taken; the user issues them only while idle.
  assign cfg_ready = 1'b1;

  // Sequencer: idle -> decode -> (sample | divide+commit | neither) -> sweep -> emit.
  ftrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: holds the millisecond counter, per-channel edge and miss state,
  // the restoring divider for numerator / period, and the result register
  // that lets a finished result wait while the sequencer goes back to idle.
  ftrp_dp #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
